@@ rtl/elt_pkg.sv @@
// Package for the edge list table: payload structs, operation codes, controller states
// and the command and status groups between the controller and the datapath.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package elt_pkg;

  localparam int unsigned VTX_W   = 4;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned VC_W    = 5;
  localparam int unsigned EDGE_W  = 2 * VTX_W;

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH,
    ST_MOVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } in_t;

  typedef struct packed {
    logic               was_present;
    logic [TOTAL_W-1:0] edge_total;
    logic               status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;
    logic issue_rd;
    logic capture;
    logic wr_ins;
    logic rd_last;
    logic wr_move;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       err;
    logic       idx_end;
    logic       rd_pend;
    logic       rd_match;
    logic       found;
    logic       full;
    logic       out_busy;
    logic [1:0] op;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/elt_dpath.sv @@
// Datapath of the edge list table: edge memory, search index, edge count,
// key and result registers, and the vertex count register.
// Depends on elt_pkg.
`default_nettype none

module elt_dpath #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [elt_pkg::VC_W-1:0]   cfg_wdata_i,
  input  elt_pkg::in_t              in_data_i,
  input  elt_pkg::cmd_t             cmd_i,
  output elt_pkg::sts_t             sts_o,
  output wire                       out_valid_o,
  input  wire                       out_ready_i,
  output elt_pkg::out_t             out_data_o
);

  localparam int unsigned SQ       = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned EDGE_CAP = (SQ > 256) ? 256 : SQ;
  localparam int unsigned AW       = $clog2(EDGE_CAP);
  localparam int unsigned CW       = $clog2(EDGE_CAP + 1);

  logic [elt_pkg::EDGE_W-1:0] mem [EDGE_CAP];

  elt_pkg::in_t               key_q;
  logic                       err_q, err_d;
  logic                       found_q;
  logic [AW-1:0]              slot_q;
  logic [CW-1:0]              idx_q;
  logic [CW-1:0]              count_q;
  logic                       rvld_q;
  logic [elt_pkg::EDGE_W-1:0] rdata_q;
  elt_pkg::out_t              out_q;
  logic                       out_valid_q;
  logic [elt_pkg::VC_W-1:0]   vc_q;

  logic [CW-1:0]              idx_m1, count_m1;
  logic [elt_pkg::EDGE_W-1:0] key_pair;
  logic                       rd_match;
  logic                       we, re;
  logic [AW-1:0]              waddr, raddr;
  logic [elt_pkg::EDGE_W-1:0] wdata;

  assign idx_m1   = idx_q - CW'(1);
  assign count_m1 = count_q - CW'(1);
  assign key_pair = {key_q.src_vertex, key_q.dst_vertex};
  assign rd_match = rvld_q && (rdata_q == key_pair);

  // A vertex is out of range if it is not below the configured count or the build limit.
  always_comb begin
    err_d = ({1'b0, in_data_i.src_vertex} >= vc_q) ||
            ({1'b0, in_data_i.dst_vertex} >= vc_q) ||
            (int'(in_data_i.src_vertex) >= MAX_VERTICES) ||
            (int'(in_data_i.dst_vertex) >= MAX_VERTICES);
  end

  always_comb begin
    we    = cmd_i.wr_ins || cmd_i.wr_move;
    waddr = cmd_i.wr_move ? slot_q : count_q[AW-1:0];
    wdata = cmd_i.wr_move ? rdata_q : key_pair;
    re    = cmd_i.issue_rd || cmd_i.rd_last;
    raddr = cmd_i.rd_last ? count_m1[AW-1:0] : idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= in_data_i;
    end
    if (cmd_i.capture) begin
      slot_q <= idx_m1[AW-1:0];
    end
    if (cmd_i.load_out) begin
      out_q.was_present <= found_q;
      out_q.edge_total  <= elt_pkg::TOTAL_W'(count_q);
      out_q.status      <= err_q ? elt_pkg::STATUS_RANGE : elt_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vc_q        <= elt_pkg::VC_RESET;
    end else begin
      rvld_q <= cmd_i.issue_rd;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      if (cmd_i.load_key) begin
        err_q   <= err_d;
        found_q <= 1'b0;
        idx_q   <= '0;
      end else if (cmd_i.issue_rd) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.capture) begin
        found_q <= 1'b1;
      end
      if (cmd_i.wr_ins) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.wr_move) begin
        count_q <= count_m1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.err      = err_q;
    sts_o.idx_end  = (idx_q == count_q);
    sts_o.rd_pend  = rvld_q;
    sts_o.rd_match = rd_match;
    sts_o.found    = found_q;
    sts_o.full     = (count_q == CW'(EDGE_CAP));
    sts_o.out_busy = out_valid_q && !out_ready_i;
    sts_o.op       = key_q.op;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/elt_ctrl.sv @@
// Controller of the edge list table: sequences search, insert, delete and
// result hand-off through commands to the datapath.
// Depends on elt_pkg.
`default_nettype none

module elt_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  elt_pkg::sts_t sts_i,
  output elt_pkg::cmd_t cmd_o
);

  elt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= elt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      elt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = elt_pkg::ST_SEARCH;
        end
      end
      elt_pkg::ST_SEARCH: begin
        if (sts_i.err) begin
          state_d = elt_pkg::ST_DONE;
        end else if (sts_i.rd_match) begin
          cmd_o.capture = 1'b1;
          state_d       = elt_pkg::ST_FINISH;
        end else if (sts_i.idx_end && !sts_i.rd_pend) begin
          state_d = elt_pkg::ST_FINISH;
        end else if (!sts_i.idx_end) begin
          cmd_o.issue_rd = 1'b1;
        end
      end
      elt_pkg::ST_FINISH: begin
        state_d = elt_pkg::ST_DONE;
        if (sts_i.op == elt_pkg::OP_INSERT && !sts_i.found && !sts_i.full) begin
          cmd_o.wr_ins = 1'b1;
        end else if (sts_i.op == elt_pkg::OP_DELETE && sts_i.found) begin
          cmd_o.rd_last = 1'b1;
          state_d       = elt_pkg::ST_MOVE;
        end
      end
      elt_pkg::ST_MOVE: begin
        cmd_o.wr_move = 1'b1;
        state_d       = elt_pkg::ST_DONE;
      end
      elt_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = elt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = elt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/edge_list_table.sv @@
// Edge list table. A transaction passes the search, which reads the stored edges in order
// until the pair is found or all are read, the finish state, the move state for a delete of
// a found pair, and the done state, where the result loads; a range error skips to done.
// One transaction is handled at a time, the next taken in the cycle after the result loads;
// the memory search, one read per cycle, sets how long each transaction takes.
// Reset: asynchronous, active low; clears the edge count, sets vertex_count to 16.
`default_nettype none

module edge_list_table #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire [elt_pkg::VC_W-1:0] cfg_wdata_i,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  elt_pkg::in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output elt_pkg::out_t           out_data_o
);

  // The controller walks each transaction through a linear search of the packed edge
  // list, one memory read issued per cycle with the compare in the cycle after it. An
  // insert appends at the current count when the pair was absent and the table has
  // room; a delete reads the last entry and writes it into the freed slot.

  // The result sits in an output register, so a new input transaction is taken while
  // the previous result still waits; the controller only stalls before loading a new
  // result over one that was not yet taken.

  // Edge memory contents are not cleared and no clearing pass runs; only slots below
  // the edge count are ever read.

  elt_pkg::cmd_t cmd;
  elt_pkg::sts_t sts;

  elt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  elt_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/elt_checker.sv @@
// Port-level checker for the edge list table, bound to the top level.
// Depends on elt_pkg and edge_list_table.
`default_nettype none

module elt_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input elt_pkg::out_t out_data_o,
  input wire           out_valid_o,
  input wire           out_ready_i
);

  // A result that is not taken stays and does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Only one transaction is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction was in work");

  // A rejected transaction never reports the edge as present.
  a_range_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == elt_pkg::STATUS_RANGE |-> !out_data_o.was_present)
    else $error("out-of-range transaction reported a present edge");

  // The table never holds more edges than its capacity.
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.edge_total <= 9'd256)
    else $error("edge total above capacity");

endmodule

bind edge_list_table elt_checker u_elt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

`default_nettype wire
